// File: src/kplock_pkg.sv
`timescale 1ns / 1ps

package kplock_pkg;

   // Entry buffer geometry.
   localparam int CODE_DIGITS = 4;
   localparam int DIGIT_BITS  = 3;
   localparam int CODE_BITS   = CODE_DIGITS * DIGIT_BITS;
   localparam int ENTRY_BITS  = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;

   // Highest digit that counts as a real button.
   localparam logic [DIGIT_BITS-1:0] DIGIT_MAX = 3'd5;

   // Timers and counters.
   localparam int TIMER_BITS  = 16;
   localparam int TOGGLE_BITS = 8;
   localparam int MISS_BITS   = 3;
   localparam int EVENT_BITS  = 3;
   localparam int LED_BITS    = 3;
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

   // Miss counts that start the warning phase and the lockdown.
   localparam logic [MISS_BITS-1:0] WARN_MISSES = 3'd3;
   localparam logic [MISS_BITS-1:0] LOCK_MISSES = 3'd4;

   // Operating modes as reported on the result channel.
   localparam int MODE_BITS = 2;
   localparam logic [MODE_BITS-1:0] MODE_NORMAL   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_WARNING  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_LOCKDOWN = 2'd2;

   // Input item kinds.
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_PRESS = 1'b1;

   // Configuration register indexes.
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_USER_CODE     = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ADMIN_CODE    = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_WARN_PERIOD   = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_WARN_TOGGLES  = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_BLINK_TICKS   = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_STEADY_TICKS  = 3'd5;

   // Configuration reset values.
   localparam logic [CODE_BITS-1:0]   USER_CODE_RST     = 12'd585;
   localparam logic [CODE_BITS-1:0]   ADMIN_CODE_RST    = 12'd2340;
   localparam logic [TIMER_BITS-1:0]  WARN_PERIOD_RST   = 16'd100;
   localparam logic [TOGGLE_BITS-1:0] WARN_TOGGLES_RST  = 8'd30;
   localparam logic [TIMER_BITS-1:0]  BLINK_TICKS_RST   = 16'd50;
   localparam logic [TIMER_BITS-1:0]  STEADY_TICKS_RST  = 16'd6000;

   // Stream widths.
   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = 16;

   // Result field positions in rsp_tdata.
   localparam int RSP_LED_ONE   = 0;
   localparam int RSP_LED_TWO   = 1;
   localparam int RSP_LED_THREE = 2;
   localparam int RSP_MODE_LO   = 3;
   localparam int RSP_ENTRY_LO  = 5;
   localparam int RSP_MISS_LO   = 7;
   localparam int RSP_EVENT_LO  = 10;
   localparam int RSP_CHECKED   = 13;
   localparam int RSP_ACCEPTED  = 14;

   // Saturating increment shared by both timers.
   function automatic logic [TIMER_BITS-1:0] timer_inc(input logic [TIMER_BITS-1:0] t);
      return (t == TIMER_MAX) ? t : t + 1'b1;
   endfunction

endpackage

// File: src/keypad_lock_with_lockout_unit.sv
`timescale 1ns / 1ps

// Passcode lock controller. Every input item is either one time tick (req_tuser low) or a
// button press (req_tuser high, button number in req_tdata; buttons 6 and 7 are ignored).
// Each accepted item produces exactly one result item that reports the LEDs, the mode and
// the counters as they stand after that item, plus whether a full four-digit code was just
// compared and whether it matched. The block handles one item per clock cycle while no
// result is stalled: the whole update is one pass of logic from the state registers into
// the state and result registers, so a result is registered and valid in the cycle after
// its item is accepted. req_tready stays high while the result register is empty or is
// being taken in the same cycle, so a stalled result stalls the input only while it lasts.
// Users must write codes, timer periods and the warning toggle count through the csr_ port
// only while the block is idle (unenforced); a write past the last index is ignored.

module keypad_lock_with_lockout_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   // Input items.
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [kplock_pkg::REQ_DATA_BITS-1:0]   req_tdata,   // [2:0] digit, rest zero
   input  logic                                   req_tuser,   // [0] opcode
   // Result items.
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [0] led_one, [1] led_two, [2] led_three, [4:3] mode, [6:5] digits_entered,
   // [9:7] wrong_attempts, [12:10] event_count, [13] code_checked, [14] code_accepted,
   // [15] zero
   output logic [kplock_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // Configuration writes.
   input  logic                                   csr_we,
   input  logic [kplock_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [kplock_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   // Configuration registers.
   logic [kplock_pkg::CODE_BITS-1:0]   user_code_ff;
   logic [kplock_pkg::CODE_BITS-1:0]   admin_code_ff;
   logic [kplock_pkg::TIMER_BITS-1:0]  warn_period_ff;
   logic [kplock_pkg::TOGGLE_BITS-1:0] warn_toggles_ff;
   logic [kplock_pkg::TIMER_BITS-1:0]  blink_ticks_ff;
   logic [kplock_pkg::TIMER_BITS-1:0]  steady_ticks_ff;

   // Lock state.
   logic [kplock_pkg::MODE_BITS-1:0]   mode_ff,      mode_in;
   logic [kplock_pkg::DIGIT_BITS-1:0]  digits_ff     [kplock_pkg::CODE_DIGITS];
   logic [kplock_pkg::DIGIT_BITS-1:0]  digits_in     [kplock_pkg::CODE_DIGITS];
   logic [kplock_pkg::ENTRY_BITS-1:0]  entry_cnt_ff, entry_cnt_in;
   logic [kplock_pkg::MISS_BITS-1:0]   miss_ff,      miss_in;
   logic [kplock_pkg::EVENT_BITS-1:0]  events_ff,    events_in;
   logic [kplock_pkg::TIMER_BITS-1:0]  blink_ff,     blink_in;
   logic [kplock_pkg::TIMER_BITS-1:0]  phase_ff,     phase_in;
   logic [kplock_pkg::TOGGLE_BITS-1:0] toggles_ff,   toggles_in;
   logic [kplock_pkg::LED_BITS-1:0]    led_ff,       led_in;

   // Result register.
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [kplock_pkg::RSP_DATA_BITS-1:0] rsp_data_ff,  rsp_data_in;

   // Decoded item and helpers.
   logic                                 req_accept;
   logic                                 opcode;
   logic [kplock_pkg::DIGIT_BITS-1:0]    digit;
   logic                                 press;
   logic                                 entry_full;
   logic [kplock_pkg::CODE_BITS-1:0]     entry_code;
   logic                                 user_match;
   logic                                 admin_match;
   logic [kplock_pkg::TIMER_BITS-1:0]    blink_step;
   logic [kplock_pkg::TIMER_BITS-1:0]    phase_step;
   logic [kplock_pkg::MISS_BITS-1:0]     miss_step;
   logic [kplock_pkg::LED_BITS-1:0]      led_lock;
   logic                                 checked;
   logic                                 accepted;

   // A new item goes in whenever the result register is free or drains this cycle.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign opcode = req_tuser;
   assign digit  = req_tdata[kplock_pkg::DIGIT_BITS-1:0];
   assign press  = (opcode == kplock_pkg::OP_PRESS) && (digit <= kplock_pkg::DIGIT_MAX);

   // The buffer is full once this press lands in its last slot.
   assign entry_full = (entry_cnt_ff == kplock_pkg::ENTRY_BITS'(kplock_pkg::CODE_DIGITS - 1));

   // Code as it would read with the current press in its slot; only used when full.
   always_comb begin
      for (int i = 0; i < kplock_pkg::CODE_DIGITS; i++) begin
         if (entry_cnt_ff == kplock_pkg::ENTRY_BITS'(i)) begin
            entry_code[i*kplock_pkg::DIGIT_BITS +: kplock_pkg::DIGIT_BITS] = digit;
         end else begin
            entry_code[i*kplock_pkg::DIGIT_BITS +: kplock_pkg::DIGIT_BITS] = digits_ff[i];
         end
      end
   end

   assign user_match  = (entry_code == user_code_ff);
   assign admin_match = (entry_code == admin_code_ff);

   assign blink_step = kplock_pkg::timer_inc(blink_ff);
   assign phase_step = kplock_pkg::timer_inc(phase_ff);
   assign miss_step  = miss_ff + 1'b1;

   // LEDs for a lockdown tick still in the blinking phase: LED2 on, LED3 may toggle.
   always_comb begin
      led_lock = led_ff | 3'b010;
      if (blink_step >= blink_ticks_ff) begin
         led_lock = led_lock ^ 3'b100;
      end
   end

   // Next state for one item.
   always_comb begin
      mode_in      = mode_ff;
      digits_in    = digits_ff;
      entry_cnt_in = entry_cnt_ff;
      miss_in      = miss_ff;
      events_in    = events_ff;
      blink_in     = blink_ff;
      phase_in     = phase_ff;
      toggles_in   = toggles_ff;
      led_in       = led_ff;
      checked      = 1'b0;
      accepted     = 1'b0;

      // Presses are buffered in normal mode and in lockdown, never during a warning.
      if (press && (mode_ff != kplock_pkg::MODE_WARNING)) begin
         digits_in[entry_cnt_ff] = digit;
         entry_cnt_in = entry_full ? '0 : entry_cnt_ff + 1'b1;
      end

      case (mode_ff)
         kplock_pkg::MODE_WARNING: begin
            if (opcode == kplock_pkg::OP_TICK) begin
               blink_in = blink_step;
               if (blink_step >= warn_period_ff) begin
                  blink_in = '0;
                  if (toggles_ff >= warn_toggles_ff) begin
                     mode_in    = kplock_pkg::MODE_NORMAL;
                     led_in     = '0;
                     toggles_in = '0;
                  end else begin
                     led_in     = led_ff ^ 3'b001;
                     toggles_in = toggles_ff + 1'b1;
                  end
               end
            end
         end
         kplock_pkg::MODE_LOCKDOWN: begin
            if (opcode == kplock_pkg::OP_TICK) begin
               if (phase_step >= steady_ticks_ff) begin
                  // Blinking is over: show the lockdown count in binary.
                  phase_in = steady_ticks_ff;
                  led_in   = events_ff;
               end else begin
                  phase_in = phase_step;
                  led_in   = led_lock;
                  blink_in = (blink_step >= blink_ticks_ff) ? '0 : blink_step;
               end
            end else if (press && entry_full) begin
               checked = 1'b1;
               if (admin_match) begin
                  accepted = 1'b1;
                  mode_in  = kplock_pkg::MODE_NORMAL;
                  miss_in  = '0;
                  blink_in = '0;
                  phase_in = '0;
                  led_in   = '0;
               end
            end
         end
         default: begin
            mode_in = kplock_pkg::MODE_NORMAL;
            if (press && entry_full) begin
               checked = 1'b1;
               if (user_match) begin
                  accepted  = 1'b1;
                  miss_in   = '0;
                  events_in = '0;
                  led_in    = '0;
               end else begin
                  miss_in = miss_step;
                  if (miss_step == kplock_pkg::WARN_MISSES) begin
                     // LED1 comes on at once and counts as the first toggle.
                     mode_in    = kplock_pkg::MODE_WARNING;
                     blink_in   = '0;
                     led_in     = led_ff ^ 3'b001;
                     toggles_in = kplock_pkg::TOGGLE_BITS'(1);
                  end else if (miss_step == kplock_pkg::LOCK_MISSES) begin
                     mode_in   = kplock_pkg::MODE_LOCKDOWN;
                     events_in = events_ff + 1'b1;
                     blink_in  = '0;
                     phase_in  = '0;
                     led_in    = 3'b010;
                  end
               end
            end
         end
      endcase
   end

   // Result item packed from the state after this item.
   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[kplock_pkg::RSP_LED_ONE]   = led_in[0];
      rsp_data_in[kplock_pkg::RSP_LED_TWO]   = led_in[1];
      rsp_data_in[kplock_pkg::RSP_LED_THREE] = led_in[2];
      rsp_data_in[kplock_pkg::RSP_MODE_LO +: kplock_pkg::MODE_BITS] = mode_in;
      rsp_data_in[kplock_pkg::RSP_ENTRY_LO +: 2] = 2'(entry_cnt_in);
      rsp_data_in[kplock_pkg::RSP_MISS_LO +: kplock_pkg::MISS_BITS]   = miss_in;
      rsp_data_in[kplock_pkg::RSP_EVENT_LO +: kplock_pkg::EVENT_BITS] = events_in;
      rsp_data_in[kplock_pkg::RSP_CHECKED]  = checked;
      rsp_data_in[kplock_pkg::RSP_ACCEPTED] = accepted;
   end

   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_tready);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         user_code_ff    <= kplock_pkg::USER_CODE_RST;
         admin_code_ff   <= kplock_pkg::ADMIN_CODE_RST;
         warn_period_ff  <= kplock_pkg::WARN_PERIOD_RST;
         warn_toggles_ff <= kplock_pkg::WARN_TOGGLES_RST;
         blink_ticks_ff  <= kplock_pkg::BLINK_TICKS_RST;
         steady_ticks_ff <= kplock_pkg::STEADY_TICKS_RST;
      end else if (csr_we) begin
         case (csr_addr)
            kplock_pkg::CSR_USER_CODE:    user_code_ff    <= csr_wdata[kplock_pkg::CODE_BITS-1:0];
            kplock_pkg::CSR_ADMIN_CODE:   admin_code_ff   <= csr_wdata[kplock_pkg::CODE_BITS-1:0];
            kplock_pkg::CSR_WARN_PERIOD:  warn_period_ff  <= csr_wdata[kplock_pkg::TIMER_BITS-1:0];
            kplock_pkg::CSR_WARN_TOGGLES: warn_toggles_ff <= csr_wdata[kplock_pkg::TOGGLE_BITS-1:0];
            kplock_pkg::CSR_BLINK_TICKS:  blink_ticks_ff  <= csr_wdata[kplock_pkg::TIMER_BITS-1:0];
            kplock_pkg::CSR_STEADY_TICKS: steady_ticks_ff <= csr_wdata[kplock_pkg::TIMER_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Lock state and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= kplock_pkg::MODE_NORMAL;
         entry_cnt_ff <= '0;
         miss_ff      <= '0;
         events_ff    <= '0;
         blink_ff     <= '0;
         phase_ff     <= '0;
         toggles_ff   <= '0;
         led_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            mode_ff      <= mode_in;
            entry_cnt_ff <= entry_cnt_in;
            miss_ff      <= miss_in;
            events_ff    <= events_in;
            blink_ff     <= blink_in;
            phase_ff     <= phase_in;
            toggles_ff   <= toggles_in;
            led_ff       <= led_in;
         end
      end
   end

   // Entry digits and result payload need no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         digits_ff   <= digits_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: src/kplock_checker.sv
`timescale 1ns / 1ps

module kplock_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [kplock_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   // A stalled result stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Every accepted item shows up as a result in the next cycle.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted item produced no result");

   // No result is pending right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A match can only be reported on a compare.
   a_accept_checked: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[kplock_pkg::RSP_ACCEPTED] |-> rsp_tdata[kplock_pkg::RSP_CHECKED])
      else $error("code accepted without a compare");

   // A compare always empties the entry buffer.
   a_checked_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[kplock_pkg::RSP_CHECKED]
      |-> rsp_tdata[kplock_pkg::RSP_ENTRY_LO +: 2] == 2'd0)
      else $error("entry buffer not cleared after compare");

endmodule

bind keypad_lock_with_lockout_unit kplock_checker u_kplock_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: test/kplock_status_check.sv
`timescale 1ns / 1ps

module kplock_status_check (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic [kplock_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                                 req_tuser,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [kplock_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                                 csr_we,
   input  logic [kplock_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [kplock_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output int unsigned                          fail_count,
   output int unsigned                          pending,
   output int unsigned                          results_seen,
   output int unsigned                          codes_matched,
   output int unsigned                          warnings_started,
   output int unsigned                          lockdowns_started
);
   import kplock_pkg::*;

   // Result fields, highest bit first so the struct lines up with rsp_tdata.
   typedef struct packed {
      logic                  accepted;
      logic                  checked;
      logic [EVENT_BITS-1:0] events;
      logic [MISS_BITS-1:0]  misses;
      logic [ENTRY_BITS-1:0] entered;
      logic [MODE_BITS-1:0]  mode;
      logic                  led_three;
      logic                  led_two;
      logic                  led_one;
   } lock_status_type;

   // Register copies.
   logic [CODE_BITS-1:0]   user_code_q;
   logic [CODE_BITS-1:0]   admin_code_q;
   logic [TIMER_BITS-1:0]  warn_period_q;
   logic [TOGGLE_BITS-1:0] warn_toggles_q;
   logic [TIMER_BITS-1:0]  blink_ticks_q;
   logic [TIMER_BITS-1:0]  steady_ticks_q;

   // Lock state as the block should hold it.
   logic [MODE_BITS-1:0]   lock_mode;
   logic [DIGIT_BITS-1:0]  entry_buf [CODE_DIGITS];
   logic [ENTRY_BITS-1:0]  entry_cnt;
   logic [MISS_BITS-1:0]   misses;
   logic [EVENT_BITS-1:0]  lock_events;
   logic [TIMER_BITS-1:0]  blink_tmr;
   logic [TIMER_BITS-1:0]  phase_tmr;
   logic [TOGGLE_BITS-1:0] toggles_done;
   logic [LED_BITS-1:0]    leds;

   lock_status_type status_q [$];
   lock_status_type want_st;
   lock_status_type seen_st;

   function automatic logic [TIMER_BITS-1:0] bump_timer(input logic [TIMER_BITS-1:0] t);
      logic [TIMER_BITS:0] wide;
      wide = {1'b0, t} + 1'b1;
      return wide[TIMER_BITS] ? t : wide[TIMER_BITS-1:0];
   endfunction

   // Stores one digit and reports whether that completed a code.
   function automatic logic store_digit(input logic [DIGIT_BITS-1:0] dig);
      entry_buf[entry_cnt] = dig;
      if (entry_cnt == ENTRY_BITS'(CODE_DIGITS - 1)) begin
         entry_cnt = '0;
         return 1'b1;
      end
      entry_cnt = entry_cnt + 1'b1;
      return 1'b0;
   endfunction

   function automatic logic entry_is(input logic [CODE_BITS-1:0] code);
      int i;
      for (i = 0; i < CODE_DIGITS; i++) begin
         if (entry_buf[i] != code[DIGIT_BITS*i +: DIGIT_BITS]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic lock_status_type advance_lock(input logic op,
                                                    input logic [DIGIT_BITS-1:0] dig);
      lock_status_type st;
      logic            press;
      st = '0;
      press = (op == OP_PRESS) && (dig <= DIGIT_MAX);
      if (lock_mode == MODE_WARNING) begin
         if (op == OP_TICK) begin
            blink_tmr = bump_timer(blink_tmr);
            if (blink_tmr >= warn_period_q) begin
               blink_tmr = '0;
               if (toggles_done >= warn_toggles_q) begin
                  lock_mode = MODE_NORMAL;
                  leds = '0;
                  toggles_done = '0;
               end else begin
                  leds[0] = ~leds[0];
                  toggles_done = toggles_done + 1'b1;
               end
            end
         end
      end else if (lock_mode == MODE_LOCKDOWN) begin
         if (op == OP_TICK) begin
            phase_tmr = bump_timer(phase_tmr);
            if (phase_tmr >= steady_ticks_q) begin
               phase_tmr = steady_ticks_q;
               leds = lock_events;
            end else begin
               leds[1] = 1'b1;
               blink_tmr = bump_timer(blink_tmr);
               if (blink_tmr >= blink_ticks_q) begin
                  leds[2] = ~leds[2];
                  blink_tmr = '0;
               end
            end
         end else if (press) begin
            if (store_digit(dig)) begin
               st.checked = 1'b1;
               if (entry_is(admin_code_q)) begin
                  st.accepted = 1'b1;
                  codes_matched++;
                  lock_mode = MODE_NORMAL;
                  misses = '0;
                  blink_tmr = '0;
                  phase_tmr = '0;
                  leds = '0;
               end
            end
         end
      end else begin
         lock_mode = MODE_NORMAL;
         if (press) begin
            if (store_digit(dig)) begin
               st.checked = 1'b1;
               if (entry_is(user_code_q)) begin
                  st.accepted = 1'b1;
                  codes_matched++;
                  misses = '0;
                  lock_events = '0;
                  leds = '0;
               end else begin
                  misses = misses + 1'b1;
                  if (misses == WARN_MISSES) begin
                     warnings_started++;
                     lock_mode = MODE_WARNING;
                     blink_tmr = '0;
                     leds[0] = ~leds[0];
                     toggles_done = TOGGLE_BITS'(1);
                  end else if (misses == LOCK_MISSES) begin
                     lockdowns_started++;
                     lock_mode = MODE_LOCKDOWN;
                     lock_events = lock_events + 1'b1;
                     blink_tmr = '0;
                     phase_tmr = '0;
                     leds = 3'b010;
                  end
               end
            end
         end
      end
      st.led_one   = leds[0];
      st.led_two   = leds[1];
      st.led_three = leds[2];
      st.mode      = lock_mode;
      st.entered   = entry_cnt;
      st.misses    = misses;
      st.events    = lock_events;
      return st;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] seen);
      if (seen !== want) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, seen);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         user_code_q    = USER_CODE_RST;
         admin_code_q   = ADMIN_CODE_RST;
         warn_period_q  = WARN_PERIOD_RST;
         warn_toggles_q = WARN_TOGGLES_RST;
         blink_ticks_q  = BLINK_TICKS_RST;
         steady_ticks_q = STEADY_TICKS_RST;
         lock_mode      = MODE_NORMAL;
         entry_cnt      = '0;
         misses         = '0;
         lock_events    = '0;
         blink_tmr      = '0;
         phase_tmr      = '0;
         toggles_done   = '0;
         leds           = '0;
         status_q.delete();
         fail_count        = 0;
         results_seen      = 0;
         codes_matched     = 0;
         warnings_started  = 0;
         lockdowns_started = 0;
      end else begin
         // Results first, so a stray result never pairs with this edge's item.
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (status_q.size() == 0) begin
               $display("%0t: result item %h arrived, expected none", $time, rsp_tdata);
               fail_count++;
            end else begin
               want_st = status_q.pop_front();
               seen_st = lock_status_type'(rsp_tdata[RSP_ACCEPTED:0]);
               check_field("led_one", 8'(want_st.led_one), 8'(seen_st.led_one));
               check_field("led_two", 8'(want_st.led_two), 8'(seen_st.led_two));
               check_field("led_three", 8'(want_st.led_three), 8'(seen_st.led_three));
               check_field("mode", 8'(want_st.mode), 8'(seen_st.mode));
               check_field("digits_entered", 8'(want_st.entered), 8'(seen_st.entered));
               check_field("wrong_attempts", 8'(want_st.misses), 8'(seen_st.misses));
               check_field("event_count", 8'(want_st.events), 8'(seen_st.events));
               check_field("code_checked", 8'(want_st.checked), 8'(seen_st.checked));
               check_field("code_accepted", 8'(want_st.accepted), 8'(seen_st.accepted));
               check_field("padding bit", 8'd0, 8'(rsp_tdata[RSP_DATA_BITS-1]));
            end
         end
         if (req_tvalid && req_tready)
            status_q.push_back(advance_lock(req_tuser, req_tdata[DIGIT_BITS-1:0]));
         if (csr_we) begin
            case (csr_addr)
               CSR_USER_CODE:    user_code_q    = csr_wdata[CODE_BITS-1:0];
               CSR_ADMIN_CODE:   admin_code_q   = csr_wdata[CODE_BITS-1:0];
               CSR_WARN_PERIOD:  warn_period_q  = csr_wdata[TIMER_BITS-1:0];
               CSR_WARN_TOGGLES: warn_toggles_q = csr_wdata[TOGGLE_BITS-1:0];
               CSR_BLINK_TICKS:  blink_ticks_q  = csr_wdata[TIMER_BITS-1:0];
               CSR_STEADY_TICKS: steady_ticks_q = csr_wdata[TIMER_BITS-1:0];
               default: ;
            endcase
         end
      end
      pending <= status_q.size();
   end

endmodule

// File: test/keypad_lock_with_lockout_unit_test.sv
`timescale 1ns / 1ps

// Top of the lock testbench. This module only makes stimulus and gives the verdict; the
// status checker beside the block watches both streams and the register port, keeps its
// own copy of the lock state and compares every result item field by field.
module keypad_lock_with_lockout_unit_test;
   import kplock_pkg::*;

   // Cycles in which no item moves on either channel before the run is declared hung.
   localparam int QUIET_LIMIT  = 2000;
   // Counted input items of the random part and the number of register settings it uses.
   localparam int RANDOM_ITEMS = 1400;
   localparam int PHASES       = 6;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic                     req_tuser  = OP_TICK;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_we     = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata  = '0;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned results_seen;
   int unsigned codes_matched;
   int unsigned warnings_started;
   int unsigned lockdowns_started;

   // Chance in percent that the sender or the receiver sits out a cycle.
   int unsigned send_idle_pct = 29;
   int unsigned recv_idle_pct = 71;
   // Ticks and real button presses sent so far; ignored buttons do not count.
   int unsigned items_sent    = 0;
   int unsigned settings_used = 0;
   int unsigned quiet_cycles  = 0;

   // The codes the block currently holds, so that the stimulus can type them.
   logic [CODE_BITS-1:0] user_code_v  = USER_CODE_RST;
   logic [CODE_BITS-1:0] admin_code_v = ADMIN_CODE_RST;

   keypad_lock_with_lockout_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   kplock_status_check status_check (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tuser         (req_tuser),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .pending           (pending),
      .results_seen      (results_seen),
      .codes_matched     (codes_matched),
      .warnings_started  (warnings_started),
      .lockdowns_started (lockdowns_started)
   );

   // 8 ns clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The receiver decides afresh every cycle whether it takes a result item.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Watchdog: ends the run if nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog: %0d cycles passed with no item accepted.", quiet_cycles);
         $display("keypad_lock_with_lockout_unit: mismatch");
         $finish;
      end
   end

   // Presents one item and returns at the edge where it is accepted. Valid stays high
   // into the next call, so back-to-back items need no second assignment in one step.
   task automatic send_item(input logic op, input logic [DIGIT_BITS-1:0] dig);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_DATA_BITS'(dig);
      do @(posedge clock); while (!req_tready);
      if (op == OP_TICK || dig <= DIGIT_MAX) items_sent++;
   endtask

   // Types the four digits of a code, first digit from the low bits. When noisy, a
   // button that does not exist is sometimes pressed in between; the block ignores it.
   task automatic enter_code(input logic [CODE_BITS-1:0] code, input logic noisy);
      int i;
      for (i = 0; i < CODE_DIGITS; i++) begin
         if (noisy && $urandom_range(0, 99) < 10)
            send_item(OP_PRESS, DIGIT_BITS'($urandom_range(6, 7)));
         send_item(OP_PRESS, code[DIGIT_BITS*i +: DIGIT_BITS]);
      end
   endtask

   // The digit field carries junk on ticks; the block must not look at it.
   task automatic tick_burst(input int unsigned count);
      int unsigned i;
      for (i = 0; i < count; i++) send_item(OP_TICK, DIGIT_BITS'($urandom_range(0, 7)));
   endtask

   // Waits until every result item the checker expects has arrived.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Writes all six registers while the block is idle.
   task automatic apply_settings(input logic [CODE_BITS-1:0]   user,
                                 input logic [CODE_BITS-1:0]   admin,
                                 input logic [TIMER_BITS-1:0]  period,
                                 input logic [TOGGLE_BITS-1:0] toggles,
                                 input logic [TIMER_BITS-1:0]  blink,
                                 input logic [TIMER_BITS-1:0]  steady);
      drain();
      write_reg(CSR_USER_CODE, CSR_DATA_BITS'(user));
      write_reg(CSR_ADMIN_CODE, CSR_DATA_BITS'(admin));
      write_reg(CSR_WARN_PERIOD, CSR_DATA_BITS'(period));
      write_reg(CSR_WARN_TOGGLES, CSR_DATA_BITS'(toggles));
      write_reg(CSR_BLINK_TICKS, CSR_DATA_BITS'(blink));
      write_reg(CSR_STEADY_TICKS, CSR_DATA_BITS'(steady));
      csr_we       <= 1'b0;
      user_code_v  = user;
      admin_code_v = admin;
      settings_used++;
   endtask

   // A code made only of real buttons.
   function automatic logic [CODE_BITS-1:0] random_code();
      logic [CODE_BITS-1:0] code;
      int i;
      for (i = 0; i < CODE_DIGITS; i++)
         code[DIGIT_BITS*i +: DIGIT_BITS] = DIGIT_BITS'($urandom_range(0, 5));
      return code;
   endfunction

   // Codes with digit 6 or 7 cannot be typed: those buttons are ignored.
   function automatic logic enterable(input logic [CODE_BITS-1:0] code);
      int i;
      for (i = 0; i < CODE_DIGITS; i++)
         if (code[DIGIT_BITS*i +: DIGIT_BITS] > DIGIT_MAX) return 1'b0;
      return 1'b1;
   endfunction

   // One random group of items. Mostly whole code entries and tick bursts, which is
   // what walks the lock through warning, lockdown and back; the rest is noise.
   task automatic random_group();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 32) begin
         enter_code(random_code(), 1'b1);
      end else if (pick < 44) begin
         enter_code(enterable(user_code_v) ? user_code_v : random_code(), 1'b1);
      end else if (pick < 62) begin
         enter_code(enterable(admin_code_v) ? admin_code_v : random_code(), 1'b1);
      end else if (pick < 92) begin
         tick_burst($urandom_range(1, 16));
      end else if ($urandom_range(0, 1) == 1) begin
         send_item(OP_PRESS, DIGIT_BITS'($urandom_range(6, 7)));
      end else begin
         tick_burst(1);
      end
   endtask

   initial begin
      int unsigned phase;
      int unsigned target;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part, first under the reset settings: user code 1111, admin 4444.
      send_item(OP_TICK, 3'd0);          // A tick in normal mode changes nothing.
      send_item(OP_PRESS, 3'd7);         // Button 7 does not exist and is ignored.
      send_item(OP_PRESS, 3'd1);
      send_item(OP_PRESS, 3'd1);
      send_item(OP_PRESS, 3'd6);         // Ignored in the middle of an entry.
      send_item(OP_PRESS, 3'd1);
      send_item(OP_PRESS, 3'd1);         // The reset user code is accepted.
      enter_code(12'o0000, 1'b0);
      enter_code(12'o5432, 1'b0);
      enter_code(12'o2345, 1'b0);        // Third miss: the warning phase starts.

      // A zero toggle count ends the warning at the end of its first period.
      apply_settings(12'o3210, 12'o5555, 16'd1, 8'd0, 16'd1, 16'd2);
      send_item(OP_PRESS, 3'd3);         // Presses are ignored while warning.
      send_item(OP_TICK, 3'd7);          // Warning over, back to normal.
      enter_code(12'o0000, 1'b0);        // Fourth miss: lockdown.
      send_item(OP_TICK, 3'd0);          // LED3 blinks on every tick.
      send_item(OP_TICK, 3'd5);          // Steady time reached: LEDs show the count.
      enter_code(12'o5555, 1'b0);        // The admin code leaves lockdown.

      // Random part. Idling shifts from a slow receiver to a slow sender and then stops.
      // One setting takes every register but the admin code to its top value, one to zero.
      for (phase = 0; phase < PHASES; phase++) begin
         if (phase == 2) begin
            send_idle_pct = 71;
            recv_idle_pct = 29;
         end else if (phase == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (phase)
            1: apply_settings(12'o7777, 12'o0000, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
            3: apply_settings(12'o0000, random_code(), '0, '0, '0, '0);
            default: apply_settings(random_code(), random_code(),
                                    TIMER_BITS'($urandom_range(1, 4)),
                                    TOGGLE_BITS'($urandom_range(1, 5)),
                                    TIMER_BITS'($urandom_range(1, 3)),
                                    TIMER_BITS'($urandom_range(1, 20)));
         endcase
         target = items_sent + RANDOM_ITEMS / PHASES;
         while (items_sent < target) random_group();
      end

      // Let the last result items drain, then give stray ones a chance to show up.
      drain();
      repeat (8) @(posedge clock);

      $display("Run covered %0d result items under %0d register settings,", results_seen,
               settings_used + 1);
      $display("with %0d codes matched, %0d warning phases and %0d lockdowns.",
               codes_matched, warnings_started, lockdowns_started);
      if (fail_count == 0) begin
         $display("keypad_lock_with_lockout_unit: match");
      end else begin
         $display("keypad_lock_with_lockout_unit: mismatch");
      end
      $finish;
   end

endmodule
